// ===== sv/midi_file_chunk_parser_unit_macros.svh =====
// Assertion macros used by the bound checker in mfcp_checker.sv.
`ifndef MIDI_FILE_CHUNK_PARSER_UNIT_MACROS_SVH
`define MIDI_FILE_CHUNK_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MFCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MFCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mfcp_pkg.sv =====
package mfcp_pkg;

    localparam logic [31:0] SIG_MTHD   = 32'h4D54_6864;
    localparam logic [31:0] SIG_MTRK   = 32'h4D54_726B;
    localparam logic [31:0] HDR_LEN_OK = 32'd6;
    localparam logic [31:0] FORMAT_MAX = 32'd2;

    typedef enum logic [3:0] {
        PH_HSIG = 4'd0,
        PH_HLEN = 4'd1,
        PH_FMT  = 4'd2,
        PH_NTRK = 4'd3,
        PH_DIV  = 4'd4,
        PH_TSIG = 4'd5,
        PH_TLEN = 4'd6,
        PH_DATA = 4'd7,
        PH_DONE = 4'd8,
        PH_ERR  = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_TRACK  = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_HDR_SIG = 2'd0,
        ERR_HDR_LEN = 2'd1,
        ERR_FORMAT  = 2'd2,
        ERR_TRK_SIG = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        t_err        error_code;
        logic [1:0]  format;
        logic [15:0] track_count;
        logic [15:0] division;
        logic [15:0] track_number;
        logic [31:0] track_length;
        logic [7:0]  data_byte;
        logic        last_of_track;
    } t_result;

endpackage

// ===== sv/mfcp_in_stage.sv =====
module mfcp_in_stage
    import mfcp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  take;

    assign o_stall = r_valid && !i_advance;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/mfcp_core.sv =====
module mfcp_core
    import mfcp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output logic    o_emit,
    output t_result o_result
);

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_cnt,    n_cnt;
    logic [31:0] r_acc,    n_acc;
    logic [1:0]  r_fmt,    n_fmt;
    logic [15:0] r_ntrk,   n_ntrk;
    logic [15:0] r_div,    n_div;
    logic [15:0] r_cur,    n_cur;
    logic [31:0] r_rem,    n_rem;

    t_phase      b_phase;
    logic [1:0]  b_cnt;
    logic [31:0] b_acc;
    logic [1:0]  b_fmt;
    logic [15:0] b_ntrk;
    logic [15:0] b_div;
    logic [15:0] b_cur;
    logic [31:0] b_rem;
    logic        start;
    logic [31:0] acc_new;
    logic [31:0] rem_dec;
    logic        four_byte;
    logic        two_byte;
    logic        field_done;
    logic        trk_final;
    logic [16:0] cur_inc;

    assign start   = i_item.file_start;
    assign b_phase = start ? PH_HSIG : r_phase;
    assign b_cnt   = start ? 2'd0    : r_cnt;
    assign b_acc   = start ? 32'd0   : r_acc;
    assign b_fmt   = start ? 2'd0    : r_fmt;
    assign b_ntrk  = start ? 16'd0   : r_ntrk;
    assign b_div   = start ? 16'd0   : r_div;
    assign b_cur   = start ? 16'd0   : r_cur;
    assign b_rem   = start ? 32'd0   : r_rem;

    assign acc_new = (b_cnt == 2'd0) ? {24'd0, i_item.in_byte}
                                     : {b_acc[23:0], i_item.in_byte};
    assign rem_dec = b_rem - 32'd1;
    assign cur_inc = {1'b0, b_cur} + 17'd1;
    assign trk_final = cur_inc >= {1'b0, b_ntrk};

    always_comb begin
        four_byte = 1'b0;
        two_byte  = 1'b0;
        case (b_phase)
            PH_HSIG, PH_HLEN, PH_TSIG, PH_TLEN: four_byte = 1'b1;
            PH_FMT, PH_NTRK, PH_DIV:            two_byte  = 1'b1;
            default: ;
        endcase
    end

    assign field_done = (four_byte && b_cnt == 2'd3) || (two_byte && b_cnt == 2'd1);

    // Next state
    always_comb begin
        n_phase = b_phase;
        n_cnt   = b_cnt;
        n_acc   = b_acc;
        n_fmt   = b_fmt;
        n_ntrk  = b_ntrk;
        n_div   = b_div;
        n_cur   = b_cur;
        n_rem   = b_rem;
        if (b_phase == PH_DATA) begin
            n_rem = rem_dec;
            if (rem_dec == 32'd0) begin
                if (trk_final) begin
                    n_phase = PH_DONE;
                end else begin
                    n_cur   = cur_inc[15:0];
                    n_phase = PH_TSIG;
                end
            end
        end else if (four_byte || two_byte) begin
            n_acc = acc_new;
            if (!field_done) begin
                n_cnt = b_cnt + 2'd1;
            end else begin
                n_cnt = 2'd0;
                unique case (b_phase)
                    PH_HSIG: n_phase = (acc_new == SIG_MTHD) ? PH_HLEN : PH_ERR;
                    PH_HLEN: n_phase = (acc_new == HDR_LEN_OK) ? PH_FMT : PH_ERR;
                    PH_FMT: begin
                        if (acc_new > FORMAT_MAX) begin
                            n_phase = PH_ERR;
                        end else begin
                            n_fmt   = acc_new[1:0];
                            n_phase = PH_NTRK;
                        end
                    end
                    PH_NTRK: begin
                        n_ntrk  = acc_new[15:0];
                        n_phase = PH_DIV;
                    end
                    PH_DIV: begin
                        n_div   = acc_new[15:0];
                        n_phase = (b_ntrk == 16'd0) ? PH_DONE : PH_TSIG;
                    end
                    PH_TSIG: n_phase = (acc_new == SIG_MTRK) ? PH_TLEN : PH_ERR;
                    PH_TLEN: begin
                        n_rem = acc_new;
                        if (acc_new == 32'd0) begin
                            if (trk_final) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_cur   = cur_inc[15:0];
                                n_phase = PH_TSIG;
                            end
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    default: n_phase = b_phase;
                endcase
            end
        end
    end

    // Result
    always_comb begin
        o_emit                 = 1'b0;
        o_result.kind          = KIND_HEADER;
        o_result.error_code    = ERR_HDR_SIG;
        o_result.format        = n_fmt;
        o_result.track_count   = n_ntrk;
        o_result.division      = n_div;
        o_result.track_number  = b_cur;
        o_result.track_length  = 32'd0;
        o_result.data_byte     = 8'd0;
        o_result.last_of_track = 1'b0;
        if (b_phase == PH_DATA) begin
            o_emit                 = 1'b1;
            o_result.kind          = KIND_DATA;
            o_result.track_length  = b_acc;
            o_result.data_byte     = i_item.in_byte;
            o_result.last_of_track = (rem_dec == 32'd0);
        end else if (field_done) begin
            unique case (b_phase)
                PH_HSIG: begin
                    o_emit              = (acc_new != SIG_MTHD);
                    o_result.kind       = KIND_ERROR;
                    o_result.error_code = ERR_HDR_SIG;
                end
                PH_HLEN: begin
                    o_emit              = (acc_new != HDR_LEN_OK);
                    o_result.kind       = KIND_ERROR;
                    o_result.error_code = ERR_HDR_LEN;
                end
                PH_FMT: begin
                    o_emit              = (acc_new > FORMAT_MAX);
                    o_result.kind       = KIND_ERROR;
                    o_result.error_code = ERR_FORMAT;
                end
                PH_DIV: begin
                    o_emit        = 1'b1;
                    o_result.kind = KIND_HEADER;
                end
                PH_TSIG: begin
                    o_emit              = (acc_new != SIG_MTRK);
                    o_result.kind       = KIND_ERROR;
                    o_result.error_code = ERR_TRK_SIG;
                end
                PH_TLEN: begin
                    o_emit                 = 1'b1;
                    o_result.kind          = KIND_TRACK;
                    o_result.track_length  = acc_new;
                    o_result.last_of_track = (acc_new == 32'd0);
                end
                default: o_emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HSIG;
            r_cnt   <= 2'd0;
            r_acc   <= 32'd0;
            r_fmt   <= 2'd0;
            r_ntrk  <= 16'd0;
            r_div   <= 16'd0;
            r_cur   <= 16'd0;
            r_rem   <= 32'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_fmt   <= n_fmt;
            r_ntrk  <= n_ntrk;
            r_div   <= n_div;
            r_cur   <= n_cur;
            r_rem   <= n_rem;
        end
    end

endmodule

// ===== sv/mfcp_out_stage.sv =====
module mfcp_out_stage
    import mfcp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  logic    i_emit,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_advance,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire && i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_fire && i_emit) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== sv/midi_file_chunk_parser_unit.sv =====
// A byte passes through two registers: the byte itself in the input register, and
// then its result in the result register.
// Throughput: one byte per cycle; a stalled result register holds both stages.
// Bytes that complete no field and bytes in the done or error state give no result.
// Reset (synchronous, active low) empties both stages and leaves the parser
// waiting for the header signature with all captured fields at zero.
module midi_file_chunk_parser_unit
    import mfcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_file_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_error_code,
    output logic [1:0]  o_format,
    output logic [15:0] o_track_count,
    output logic [15:0] o_division,
    output logic [15:0] o_track_number,
    output logic [31:0] o_track_length,
    output logic [7:0]  o_data_byte,
    output logic        o_last_of_track
);

    t_item   in_item;
    t_item   s1_item;
    logic    s1_valid;
    logic    advance;
    logic    fire;
    logic    emit;
    t_result core_result;
    t_result out_result;

    assign in_item.in_byte    = i_in_byte;
    assign in_item.file_start = i_file_start;
    assign fire = s1_valid && advance;

    mfcp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_stall   (o_stall),
        .o_valid   (s1_valid),
        .o_item    (s1_item)
    );

    mfcp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (s1_item),
        .o_emit   (emit),
        .o_result (core_result)
    );

    mfcp_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_emit    (emit),
        .i_result  (core_result),
        .i_stall   (i_stall),
        .o_advance (advance),
        .o_valid   (o_valid),
        .o_result  (out_result)
    );

    assign o_kind          = out_result.kind;
    assign o_error_code    = out_result.error_code;
    assign o_format        = out_result.format;
    assign o_track_count   = out_result.track_count;
    assign o_division      = out_result.division;
    assign o_track_number  = out_result.track_number;
    assign o_track_length  = out_result.track_length;
    assign o_data_byte     = out_result.data_byte;
    assign o_last_of_track = out_result.last_of_track;

endmodule

// ===== sv/mfcp_checker.sv =====
`include "midi_file_chunk_parser_unit_macros.svh"

module mfcp_checker
    import mfcp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [1:0]  o_error_code,
    input logic [31:0] o_track_length,
    input logic [7:0]  o_data_byte,
    input logic        o_last_of_track
);

    `MFCP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_kind) && $stable(o_data_byte), "stalled transaction changed")
    `MFCP_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled while result register free")
    `MFCP_ASSERT_NOW(a_err_code_zero, i_clk, i_rst_n, o_valid && o_kind != KIND_ERROR, o_error_code == ERR_HDR_SIG, "error code outside error transaction")
    `MFCP_ASSERT_NOW(a_header_fields, i_clk, i_rst_n, o_valid && (o_kind == KIND_HEADER || o_kind == KIND_ERROR), o_track_length == 32'd0 && o_data_byte == 8'd0 && !o_last_of_track, "header or error carries track fields")

endmodule

bind midi_file_chunk_parser_unit mfcp_checker u_mfcp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_kind          (o_kind),
    .o_error_code    (o_error_code),
    .o_track_length  (o_track_length),
    .o_data_byte     (o_data_byte),
    .o_last_of_track (o_last_of_track)
);

// ===== sim/mfcp_chunk_checker.sv =====
module mfcp_chunk_checker
    import mfcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_file_start,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_error_code,
    input  logic [1:0]  i_format,
    input  logic [15:0] i_track_count,
    input  logic [15:0] i_division,
    input  logic [15:0] i_track_number,
    input  logic [31:0] i_track_length,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_of_track,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_phase      phase;
    logic [1:0]  field_idx;
    logic [31:0] field_acc;
    logic [1:0]  fmt_seen;
    logic [15:0] ntrk_seen;
    logic [15:0] div_seen;
    logic [15:0] track_idx;
    logic [31:0] bytes_left;

    t_result expected_results[$];
    int      mismatch_count = 0;

    function automatic void clear_parse();
        phase = PH_HSIG;
        field_idx = 2'd0;
        field_acc = 32'd0;
        fmt_seen = 2'd0;
        ntrk_seen = 16'd0;
        div_seen = 16'd0;
        track_idx = 16'd0;
        bytes_left = 32'd0;
    endfunction

    function automatic t_result make_result(input t_kind k, input logic [31:0] len,
                                            input logic [7:0] d, input logic last);
        t_result r;
        r = '0;
        r.kind = k;
        r.format = fmt_seen;
        r.track_count = ntrk_seen;
        r.division = div_seen;
        r.track_number = track_idx;
        r.track_length = len;
        r.data_byte = d;
        r.last_of_track = last;
        return r;
    endfunction

    function automatic bit reject(input t_err code, output t_result r);
        phase = PH_ERR;
        r = make_result(KIND_ERROR, 32'd0, 8'd0, 1'b0);
        r.error_code = code;
        return 1'b1;
    endfunction

    function automatic void advance_track();
        if ({16'd0, track_idx} + 32'd1 >= {16'd0, ntrk_seen}) begin
            phase = PH_DONE;
        end else begin
            track_idx = track_idx + 16'd1;
            phase = PH_TSIG;
        end
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                      output t_result r);
        int unsigned width;
        logic        last;
        r = '0;
        if (start) begin
            clear_parse();
        end
        if (phase == PH_DATA) begin
            bytes_left = bytes_left - 32'd1;
            last = (bytes_left == 32'd0);
            r = make_result(KIND_DATA, field_acc, b, last);
            if (last) begin
                advance_track();
            end
            return 1'b1;
        end
        case (phase)
            PH_HSIG, PH_HLEN, PH_TSIG, PH_TLEN: width = 4;
            PH_FMT, PH_NTRK, PH_DIV: width = 2;
            default: return 1'b0;
        endcase
        field_acc = (field_idx == 2'd0) ? {24'd0, b} : {field_acc[23:0], b};
        if (field_idx + 1 < width) begin
            field_idx = field_idx + 2'd1;
            return 1'b0;
        end
        field_idx = 2'd0;
        case (phase)
            PH_HSIG: begin
                if (field_acc != SIG_MTHD) return reject(ERR_HDR_SIG, r);
                phase = PH_HLEN;
            end
            PH_HLEN: begin
                if (field_acc != HDR_LEN_OK) return reject(ERR_HDR_LEN, r);
                phase = PH_FMT;
            end
            PH_FMT: begin
                if (field_acc > FORMAT_MAX) return reject(ERR_FORMAT, r);
                fmt_seen = field_acc[1:0];
                phase = PH_NTRK;
            end
            PH_NTRK: begin
                ntrk_seen = field_acc[15:0];
                phase = PH_DIV;
            end
            PH_DIV: begin
                div_seen = field_acc[15:0];
                phase = (ntrk_seen == 16'd0) ? PH_DONE : PH_TSIG;
                r = make_result(KIND_HEADER, 32'd0, 8'd0, 1'b0);
                return 1'b1;
            end
            PH_TSIG: begin
                if (field_acc != SIG_MTRK) return reject(ERR_TRK_SIG, r);
                phase = PH_TLEN;
            end
            default: begin
                bytes_left = field_acc;
                if (field_acc == 32'd0) begin
                    r = make_result(KIND_TRACK, 32'd0, 8'd0, 1'b1);
                    advance_track();
                end else begin
                    r = make_result(KIND_TRACK, field_acc, 8'd0, 1'b0);
                    phase = PH_DATA;
                end
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result r;
        t_result want;
        if (!i_rst_n) begin
            clear_parse();
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: kind expected none actual %0d", $time, i_kind);
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, i_kind);
                    check_field("error_code", want.error_code, i_error_code);
                    check_field("format", want.format, i_format);
                    check_field("track_count", want.track_count, i_track_count);
                    check_field("division", want.division, i_division);
                    check_field("track_number", want.track_number, i_track_number);
                    check_field("track_length", want.track_length, i_track_length);
                    check_field("data_byte", want.data_byte, i_data_byte);
                    check_field("last_of_track", want.last_of_track, i_last_of_track);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (parse_byte(i_in_byte, i_file_start, r)) begin
                    expected_results.push_back(r);
                end
            end
        end
        o_errors <= mismatch_count;
        o_pending <= expected_results.size();
    end

endmodule

// ===== sim/tb_midi_file_chunk_parser_unit.sv =====
module tb_midi_file_chunk_parser_unit;
    import mfcp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int BYTE_TARGET = 1950;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {
        FLT_NONE,
        FLT_HDR_SIG,
        FLT_HDR_LEN,
        FLT_FORMAT,
        FLT_TRK_SIG,
        FLT_NOISE
    } t_fault;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_in_byte;
    logic        i_file_start;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [1:0]  o_error_code;
    logic [1:0]  o_format;
    logic [15:0] o_track_count;
    logic [15:0] o_division;
    logic [15:0] o_track_number;
    logic [31:0] o_track_length;
    logic [7:0]  o_data_byte;
    logic        o_last_of_track;

    int fail_total;
    int pending_results;
    int bytes_sent = 0;
    int cycles = 0;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;

    midi_file_chunk_parser_unit i_dut (.*);

    mfcp_chunk_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_in_byte       (i_in_byte),
        .i_file_start    (i_file_start),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_kind          (o_kind),
        .i_error_code    (o_error_code),
        .i_format        (o_format),
        .i_track_count   (o_track_count),
        .i_division      (o_division),
        .i_track_number  (o_track_number),
        .i_track_length  (o_track_length),
        .i_data_byte     (o_data_byte),
        .i_last_of_track (o_last_of_track),
        .o_errors        (fail_total),
        .o_pending       (pending_results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_midi_file_chunk_parser_unit: errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_file_start <= start;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_be(input logic [31:0] v, input int nb, input logic start);
        for (int k = nb - 1; k >= 0; k--) begin
            send_byte(v[8*k +: 8], (k == nb - 1) ? start : 1'b0);
        end
    endtask

    task automatic send_tail();
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_file();
        t_fault      fault;
        logic [31:0] word;
        logic [15:0] ntrk;
        logic [31:0] len;
        int          ntr;
        int          bad_trk;
        int          cut;
        case ($urandom_range(0, 11))
            0: fault = FLT_HDR_SIG;
            1: fault = FLT_HDR_LEN;
            2: fault = FLT_FORMAT;
            3: fault = FLT_TRK_SIG;
            4: fault = FLT_NOISE;
            default: fault = FLT_NONE;
        endcase
        if (fault == FLT_NOISE) begin
            repeat ($urandom_range(1, 8)) begin
                send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
            return;
        end

        word = SIG_MTHD;
        if (fault == FLT_HDR_SIG) word = word ^ (32'd1 << $urandom_range(0, 31));
        send_be(word, 4, $urandom_range(0, 15) != 0);
        if (fault == FLT_HDR_SIG) begin
            send_tail();
            return;
        end

        word = HDR_LEN_OK;
        if (fault == FLT_HDR_LEN) begin
            word = ($urandom_range(0, 1) == 1) ? $urandom
                                               : word ^ (32'd1 << $urandom_range(0, 31));
        end
        send_be(word, 4, 1'b0);
        if (fault == FLT_HDR_LEN) begin
            send_tail();
            return;
        end

        if (fault == FLT_FORMAT) begin
            word = ($urandom_range(0, 1) == 1) ? 32'hFFFF : $urandom_range(3, 65535);
        end else begin
            word = $urandom_range(0, 2);
        end
        send_be(word, 2, 1'b0);
        if (fault == FLT_FORMAT) begin
            send_tail();
            return;
        end

        ntrk = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        send_be({16'd0, ntrk}, 2, 1'b0);
        send_be($urandom, 2, 1'b0);

        ntr = (ntrk > 16'd4) ? 4 : int'(ntrk);
        bad_trk = (fault == FLT_TRK_SIG && ntr > 0) ? $urandom_range(0, ntr - 1) : -1;
        for (int t = 0; t < ntr; t++) begin
            word = SIG_MTRK;
            if (t == bad_trk) word = word ^ (32'd1 << $urandom_range(0, 31));
            send_be(word, 4, 1'b0);
            if (t == bad_trk) begin
                send_tail();
                return;
            end
            len = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 10);
            send_be(len, 4, 1'b0);
            cut = (len > 32'd12) ? $urandom_range(1, 12) : int'(len);
            repeat (cut) send_byte(8'($urandom), 1'b0);
            if (len != cut) return;
        end
        if (int'(ntrk) == ntr) send_tail();
    endtask

    initial begin : receiver
        int hold;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = out_calm ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_in_byte <= 8'd0;
        i_file_start <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // parse without any start flag: one zero-length track, then trailing bytes
        send_be(SIG_MTHD, 4, 1'b0);
        send_be(HDR_LEN_OK, 4, 1'b0);
        send_be(FORMAT_MAX, 2, 1'b0);
        send_be(32'd1, 2, 1'b0);
        send_be(32'hFFFF, 2, 1'b0);
        send_be(SIG_MTRK, 4, 1'b0);
        send_be(32'd0, 4, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // restart into a bad signature, then a byte swallowed by the error state
        send_be(32'h4D54_6800, 4, 1'b1);
        send_byte(8'h4D, 1'b0);

        while (bytes_sent < BYTE_TARGET) send_file();

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_total == 0) begin
            $display("tb_midi_file_chunk_parser_unit: clean");
        end else begin
            $display("tb_midi_file_chunk_parser_unit: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/mfcp_pkg.sv
sv/mfcp_in_stage.sv
sv/mfcp_core.sv
sv/mfcp_out_stage.sv
sv/midi_file_chunk_parser_unit.sv
sv/mfcp_checker.sv
sim/mfcp_chunk_checker.sv
sim/tb_midi_file_chunk_parser_unit.sv
